>>> rtl/core/tmcr_pkg.sv
package tmcr_pkg;

	// Command codes carried on s_tuser
	typedef enum logic [1:0] {
		CMD_CELL    = 2'd0,
		CMD_PALETTE = 2'd1,
		CMD_GLYPH   = 2'd2,
		CMD_RENDER  = 2'd3
	} cmd_t;

	localparam int CMD_W     = 2;
	localparam int ROW_W     = 5;
	localparam int COL_W     = 7;
	localparam int CODE_W    = 8;
	localparam int PEN_W     = 6;
	localparam int COLOR_W   = 16;
	localparam int GROW_W    = 4;
	localparam int GBITS_W   = 8;
	localparam int LINE_W    = 9;
	localparam int PAL_DEPTH = 64;
	localparam int ENTRY_W   = 2 * COLOR_W;

	// Input tdata layout, first field in the lowest bits
	localparam int ROW_LSB   = 0;
	localparam int COL_LSB   = ROW_LSB + ROW_W;
	localparam int CODE_LSB  = COL_LSB + COL_W;
	localparam int PEN_LSB   = CODE_LSB + CODE_W;
	localparam int FG_LSB    = PEN_LSB + PEN_W;
	localparam int BG_LSB    = FG_LSB + COLOR_W;
	localparam int GROW_LSB  = BG_LSB + COLOR_W;
	localparam int GBITS_LSB = GROW_LSB + GROW_W;
	localparam int LINE_LSB  = GBITS_LSB + GBITS_W;
	localparam int S_USED_W  = LINE_LSB + LINE_W;
	localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ENTRY_W;

	// Palette entry holds bg in the upper half, fg in the lower half
	function automatic logic [COLOR_W-1:0] pick_color(input logic [ENTRY_W-1:0] entry,
			input logic fg_sel);
		pick_color = fg_sel ? entry[COLOR_W-1:0] : entry[ENTRY_W-1:COLOR_W];
	endfunction

endpackage

>>> rtl/core/tmcr_ram.sv
module tmcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/text_mode_cell_renderer.sv
// Channel | Dir | tdata                                      | tuser | tlast
// s_      | in  | row,column,char_code,pen,fg,bg,grow,bits,ln | cmd   | -
// m_      | out | pixel_pair                                 | -     | last_word
//
// Write commands never enter the output word serializer; a render cell occupies
// it for GLYPH_WIDTH/2 output words (4 at the default width), which sets the
// sustained render rate. The first word passes stages s1 to s4 before loading.
// After reset a clearing pass over max(ROWS*COLUMNS, 64) addresses (2400 at the
// defaults) zeroes the cell and palette memories; s_tready stays low meanwhile.
// A stall on m_tready freezes the whole read pipeline and its memory outputs
// once a render cell waits behind the busy serializer.
module text_mode_cell_renderer #(
	parameter int COLUMNS      = 80,
	parameter int ROWS         = 30,
	parameter int GLYPH_HEIGHT = 16,
	parameter int GLYPH_WIDTH  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// row, column, char_code, pen, fg_color, bg_color, glyph_row, glyph_bits, scan_line
	input  logic [tmcr_pkg::S_TDATA_W-1:0] s_tdata,
	// cmd
	input  logic [tmcr_pkg::CMD_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// pixel_pair
	output logic [tmcr_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast
);

	import tmcr_pkg::*;

	localparam int CELLS   = ROWS * COLUMNS;
	localparam int CA_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CLR_N   = (CELLS > PAL_DEPTH) ? CELLS : PAL_DEPTH;
	localparam int CLR_W   = $clog2(CLR_N + 1);
	localparam int FDEPTH  = 256 * GLYPH_HEIGHT;
	localparam int FA_W    = $clog2(FDEPTH);
	localparam int SUB_W   = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
	localparam int NWORDS  = GLYPH_WIDTH / 2;
	localparam int CNT_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int ALIGN   = GBITS_W - 2 * NWORDS;
	localparam int RSH     = 16;
	localparam int RECIP   = (1 << RSH) / GLYPH_HEIGHT;
	localparam int RECIP_W = RSH + 1;
	localparam int PROD_W  = LINE_W + RECIP_W;
	localparam int ADDR_W  = 16;

	// ---------------- reset clearing pass ----------------
	logic             clearing_q;
	logic [CLR_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == CLR_W'(CLR_N - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	// ---------------- stage 0: accept, reciprocal estimate ----------------
	logic              adv;
	logic              acc;
	logic [PROD_W-1:0] prod;

	assign s_tready = adv && !clearing_q;
	assign acc      = s_tvalid && s_tready;
	assign prod     = PROD_W'(s_tdata[LINE_LSB +: LINE_W]) * PROD_W'(RECIP);

	logic               v_s1;
	cmd_t               cmd_s1;
	logic [ROW_W-1:0]   row_s1;
	logic [COL_W-1:0]   column_s1;
	logic [CODE_W-1:0]  code_s1;
	logic [PEN_W-1:0]   pen_s1;
	logic [COLOR_W-1:0] fg_s1, bg_s1;
	logic [GROW_W-1:0]  grow_s1;
	logic [GBITS_W-1:0] bits_s1;
	logic [LINE_W-1:0]  line_s1;
	logic [LINE_W-1:0]  qest_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1    <= cmd_t'(s_tuser);
			row_s1    <= s_tdata[ROW_LSB +: ROW_W];
			column_s1 <= s_tdata[COL_LSB +: COL_W];
			code_s1   <= s_tdata[CODE_LSB +: CODE_W];
			pen_s1    <= s_tdata[PEN_LSB +: PEN_W];
			fg_s1     <= s_tdata[FG_LSB +: COLOR_W];
			bg_s1     <= s_tdata[BG_LSB +: COLOR_W];
			grow_s1   <= s_tdata[GROW_LSB +: GROW_W];
			bits_s1   <= s_tdata[GBITS_LSB +: GBITS_W];
			line_s1   <= s_tdata[LINE_LSB +: LINE_W];
			qest_s1   <= prod[RSH +: LINE_W];
		end
	end

	// ---------------- stage 1: quotient correction ----------------
	logic [LINE_W-1:0] qd, rem_raw, trow_c, rem_c;
	logic              fix;

	always_comb begin
		qd      = LINE_W'(qest_s1 * LINE_W'(GLYPH_HEIGHT));
		rem_raw = line_s1 - qd;
		fix     = rem_raw >= LINE_W'(GLYPH_HEIGHT);
		trow_c  = fix ? qest_s1 + 1'b1 : qest_s1;
		rem_c   = fix ? rem_raw - LINE_W'(GLYPH_HEIGHT) : rem_raw;
	end

	logic               v_s2;
	cmd_t               cmd_s2;
	logic [ROW_W-1:0]   row_s2;
	logic [COL_W-1:0]   column_s2;
	logic [CODE_W-1:0]  code_s2;
	logic [PEN_W-1:0]   pen_s2;
	logic [COLOR_W-1:0] fg_s2, bg_s2;
	logic [GROW_W-1:0]  grow_s2;
	logic [GBITS_W-1:0] bits_s2;
	logic [LINE_W-1:0]  trow_s2;
	logic [SUB_W-1:0]   sub_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2    <= cmd_s1;
			row_s2    <= row_s1;
			column_s2 <= column_s1;
			code_s2   <= code_s1;
			pen_s2    <= pen_s1;
			fg_s2     <= fg_s1;
			bg_s2     <= bg_s1;
			grow_s2   <= grow_s1;
			bits_s2   <= bits_s1;
			trow_s2   <= trow_c;
			sub_s2    <= rem_c[SUB_W-1:0];
		end
	end

	// ---------------- stage 2: cell memory access ----------------
	logic [LINE_W-1:0] sel_row;
	logic              in_rng;
	logic [ADDR_W-1:0] cell_lin;
	logic              cell_we;
	logic [CA_W-1:0]   cell_waddr;
	logic [CODE_W+PEN_W-1:0] cell_wdata, cell_rd;

	always_comb begin
		sel_row  = (cmd_s2 == CMD_CELL) ? LINE_W'(row_s2) : trow_s2;
		in_rng   = (sel_row < LINE_W'(ROWS)) && (LINE_W'(column_s2) < LINE_W'(COLUMNS));
		cell_lin = ADDR_W'(sel_row) * ADDR_W'(COLUMNS) + ADDR_W'(column_s2);
		if (clearing_q) begin
			cell_we    = clr_q < CLR_W'(CELLS);
			cell_waddr = clr_q[CA_W-1:0];
			cell_wdata = '0;
		end else begin
			cell_we    = adv && v_s2 && (cmd_s2 == CMD_CELL) && in_rng;
			cell_waddr = cell_lin[CA_W-1:0];
			cell_wdata = {pen_s2, code_s2};
		end
	end

	tmcr_ram #(.WIDTH(CODE_W + PEN_W), .DEPTH(CELLS)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.re    (adv),
		.raddr (cell_lin[CA_W-1:0]),
		.rdata (cell_rd)
	);

	logic               v_s3;
	cmd_t               cmd_s3;
	logic               ok_s3;
	logic [CODE_W-1:0]  code_s3;
	logic [PEN_W-1:0]   pen_s3;
	logic [COLOR_W-1:0] fg_s3, bg_s3;
	logic [GROW_W-1:0]  grow_s3;
	logic [GBITS_W-1:0] bits_s3;
	logic [SUB_W-1:0]   sub_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3  <= cmd_s2;
			ok_s3   <= in_rng;
			code_s3 <= code_s2;
			pen_s3  <= pen_s2;
			fg_s3   <= fg_s2;
			bg_s3   <= bg_s2;
			grow_s3 <= grow_s2;
			bits_s3 <= bits_s2;
			sub_s3  <= sub_s2;
		end
	end

	// ---------------- stage 3: font and palette access ----------------
	logic [CODE_W-1:0]  sel_code;
	logic [FA_W-1:0]    font_addr;
	logic               font_we;
	logic [GBITS_W-1:0] font_rd;
	logic               pal_we;
	logic [PEN_W-1:0]   pal_waddr;
	logic [ENTRY_W-1:0] pal_wdata, pal_rd;

	always_comb begin
		sel_code  = (cmd_s3 == CMD_GLYPH) ? code_s3 : cell_rd[CODE_W-1:0];
		font_addr = FA_W'(sel_code) * FA_W'(GLYPH_HEIGHT)
			+ ((cmd_s3 == CMD_GLYPH) ? FA_W'(grow_s3) : FA_W'(sub_s3));
		font_we   = adv && v_s3 && (cmd_s3 == CMD_GLYPH)
			&& (6'(grow_s3) < 6'(GLYPH_HEIGHT));
		if (clearing_q) begin
			pal_we    = clr_q < CLR_W'(PAL_DEPTH);
			pal_waddr = clr_q[PEN_W-1:0];
			pal_wdata = '0;
		end else begin
			pal_we    = adv && v_s3 && (cmd_s3 == CMD_PALETTE);
			pal_waddr = pen_s3;
			pal_wdata = {bg_s3, fg_s3};
		end
	end

	tmcr_ram #(.WIDTH(GBITS_W), .DEPTH(FDEPTH)) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (font_addr),
		.wdata (bits_s3),
		.re    (adv),
		.raddr (font_addr),
		.rdata (font_rd)
	);

	tmcr_ram #(.WIDTH(ENTRY_W), .DEPTH(PAL_DEPTH)) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata (pal_wdata),
		.re    (adv),
		.raddr (cell_rd[CODE_W +: PEN_W]),
		.rdata (pal_rd)
	);

	// ---------------- stage 4 and word serializer ----------------
	logic               v_s4;
	logic               busy_q;
	logic [GBITS_W-1:0] sh_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               last_w;
	logic               load;

	assign last_w = cnt_q == CNT_W'(NWORDS - 1);
	assign load   = v_s4 && (!busy_q || (m_tready && last_w));
	assign adv    = !v_s4 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			// only an in-range render moves on to the serializer
			v_s4 <= v_s3 && (cmd_s3 == CMD_RENDER) && ok_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && m_tready) begin
			if (last_w) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			// left-align the lowest 2*NWORDS bits; any font bits above them fall off
			sh_q    <= GBITS_W'(font_rd << ALIGN);
			entry_q <= pal_rd;
		end else if (busy_q && m_tready) begin
			sh_q <= sh_q << 2;
		end
	end

	assign m_tvalid = busy_q;
	assign m_tlast  = busy_q && last_w;
	assign m_tdata  = {pick_color(entry_q, sh_q[GBITS_W-2]), pick_color(entry_q, sh_q[GBITS_W-1])};

`ifndef SYNTH
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s_tready)
		else $error("transaction accepted during memory clearing");

	a_cell_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !adv) |=> v_s4)
		else $error("pending render cell lost under stall");

	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && m_tready && m_tlast && !v_s4) |=> !busy_q)
		else $error("serializer kept running after last word");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= CNT_W'(NWORDS - 1)))
		else $error("word counter beyond cell width");
`endif

endmodule

>>> tb/text_mode_cell_renderer_tb.sv
`timescale 1ns / 100ps

module text_mode_cell_renderer_tb;
	import tmcr_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS = 30;
	localparam int GLYPH_HEIGHT = 16;
	localparam int GLYPH_WIDTH = 8;
	localparam int WORDS_PER_CELL = GLYPH_WIDTH / 2;
	localparam int CELLS = ROWS * COLUMNS;
	localparam int FONT_DEPTH = 256 * GLYPH_HEIGHT;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 300;

	// Input tdata layout, row in the lowest bits
	typedef struct packed {
		logic [S_TDATA_W-S_USED_W-1:0] pad;
		logic [LINE_W-1:0]             line;
		logic [GBITS_W-1:0]            bits;
		logic [GROW_W-1:0]             grow;
		logic [COLOR_W-1:0]            bg;
		logic [COLOR_W-1:0]            fg;
		logic [PEN_W-1:0]              pen;
		logic [CODE_W-1:0]             code;
		logic [COL_W-1:0]              column;
		logic [ROW_W-1:0]              row;
	} cell_fields_t;

	typedef struct {
		cmd_t         cmd;
		cell_fields_t f;
	} cell_cmd_t;

	typedef struct {
		logic [M_TDATA_W-1:0] pixels;
		logic                 last;
	} pixel_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0]     s_tuser = CMD_CELL;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	// predictor state
	logic [CODE_W-1:0]  char_mem [CELLS] = '{default: '0};
	logic [PEN_W-1:0]   attr_mem [CELLS] = '{default: '0};
	logic [ENTRY_W-1:0] palette_mem [PAL_DEPTH] = '{default: '0};
	logic [GBITS_W-1:0] font_mem [FONT_DEPTH];

	// stimulus-side shadow, only to keep renders on written glyph rows
	logic [CODE_W-1:0] gen_char [CELLS] = '{default: '0};
	bit                gen_font_ok [FONT_DEPTH];

	cell_cmd_t   pending_cmds[$];
	cell_cmd_t   cur_cmd;
	pixel_word_t expected_words[$];
	pixel_word_t exp_w;

	int offered_cnt = 0;
	int taken_cnt = 0;
	int fail_cnt = 0;
	int cycle_cnt = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	text_mode_cell_renderer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.GLYPH_HEIGHT(GLYPH_HEIGHT),
		.GLYPH_WIDTH(GLYPH_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic cell_cmd_t random_cmd(input cmd_t kind);
		cell_cmd_t c;
		c.cmd = kind;
		c.f = cell_fields_t'(S_TDATA_W'({$urandom, $urandom, $urandom}));
		c.f.pad = '0;
		return c;
	endfunction

	task automatic model_cell_command(input cell_cmd_t c);
		int trow;
		int sub;
		int addr;
		logic [GBITS_W-1:0] glyph;
		logic [ENTRY_W-1:0] entry;
		pixel_word_t w;
		case (c.cmd)
			CMD_CELL: begin
				if (c.f.row < ROWS && c.f.column < COLUMNS) begin
					addr = c.f.row * COLUMNS + c.f.column;
					char_mem[addr] = c.f.code;
					attr_mem[addr] = c.f.pen;
				end
			end
			CMD_PALETTE: palette_mem[c.f.pen] = {c.f.bg, c.f.fg};
			CMD_GLYPH: begin
				if (c.f.grow < GLYPH_HEIGHT)
					font_mem[c.f.code * GLYPH_HEIGHT + c.f.grow] = c.f.bits;
			end
			CMD_RENDER: begin
				trow = c.f.line / GLYPH_HEIGHT;
				sub = c.f.line % GLYPH_HEIGHT;
				if (trow < ROWS && c.f.column < COLUMNS) begin
					addr = trow * COLUMNS + c.f.column;
					glyph = font_mem[char_mem[addr] * GLYPH_HEIGHT + sub];
					entry = palette_mem[attr_mem[addr]];
					// higher font bit of each pair lands in the low half
					for (int k = 0; k < WORDS_PER_CELL; k++) begin
						w.pixels[COLOR_W-1:0] = glyph[2*(WORDS_PER_CELL-1-k)+1] ?
							entry[COLOR_W-1:0] : entry[ENTRY_W-1:COLOR_W];
						w.pixels[ENTRY_W-1:COLOR_W] = glyph[2*(WORDS_PER_CELL-1-k)] ?
							entry[COLOR_W-1:0] : entry[ENTRY_W-1:COLOR_W];
						w.last = (k == WORDS_PER_CELL - 1);
						expected_words.push_back(w);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic queue_cell_command(input cell_cmd_t c);
		int trow;
		int sub;
		int addr;
		cell_cmd_t g;
		case (c.cmd)
			CMD_CELL: begin
				if (c.f.row < ROWS && c.f.column < COLUMNS)
					gen_char[c.f.row * COLUMNS + c.f.column] = c.f.code;
			end
			CMD_GLYPH: begin
				if (c.f.grow < GLYPH_HEIGHT)
					gen_font_ok[c.f.code * GLYPH_HEIGHT + c.f.grow] = 1'b1;
			end
			CMD_RENDER: begin
				trow = c.f.line / GLYPH_HEIGHT;
				sub = c.f.line % GLYPH_HEIGHT;
				if (trow < ROWS && c.f.column < COLUMNS) begin
					addr = trow * COLUMNS + c.f.column;
					// write the glyph row first if it was never written
					if (!gen_font_ok[gen_char[addr] * GLYPH_HEIGHT + sub]) begin
						g = random_cmd(CMD_GLYPH);
						g.f.code = gen_char[addr];
						g.f.grow = GROW_W'(sub);
						gen_font_ok[gen_char[addr] * GLYPH_HEIGHT + sub] = 1'b1;
						pending_cmds.push_back(g);
					end
				end
			end
			default: ;
		endcase
		pending_cmds.push_back(c);
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || taken_cnt != offered_cnt ||
				expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random_phase(input int n, input int send_pct, input int recv_pct);
		cell_cmd_t c;
		int pick;
		int mode;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			mode = $urandom_range(99);
			if (pick < 45) begin
				c = random_cmd(CMD_RENDER);
				if (mode < 50) begin
					c.f.line = LINE_W'($urandom_range(4 * GLYPH_HEIGHT - 1));
					c.f.column = COL_W'($urandom_range(7));
				end else if (mode < 90) begin
					c.f.line = LINE_W'($urandom_range(ROWS * GLYPH_HEIGHT - 1));
					c.f.column = COL_W'($urandom_range(COLUMNS - 1));
				end
			end else if (pick < 70) begin
				c = random_cmd(CMD_CELL);
				if (mode < 50) begin
					c.f.row = ROW_W'($urandom_range(3));
					c.f.column = COL_W'($urandom_range(7));
				end else if (mode < 90) begin
					c.f.row = ROW_W'($urandom_range(ROWS - 1));
					c.f.column = COL_W'($urandom_range(COLUMNS - 1));
				end
				if ($urandom_range(99) < 60)
					c.f.code = CODE_W'($urandom_range(7));
				if ($urandom_range(99) < 60)
					c.f.pen = PEN_W'($urandom_range(7));
			end else if (pick < 85) begin
				c = random_cmd(CMD_PALETTE);
				if (mode < 50)
					c.f.pen = PEN_W'($urandom_range(7));
			end else begin
				c = random_cmd(CMD_GLYPH);
				if (mode < 50)
					c.f.code = CODE_W'($urandom_range(7));
			end
			queue_cell_command(c);
		end
		wait_drained();
	endtask

	// driver: present pending commands, hold each until its transaction
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || taken_cnt == offered_cnt) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_cmd = pending_cmds.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur_cmd.f;
					s_tuser <= cur_cmd.cmd;
					offered_cnt++;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// monitor: check output words, then predict from accepted commands
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected pixel word %h last %b", m_tdata, m_tlast);
					fail_cnt++;
				end else begin
					exp_w = expected_words.pop_front();
					if (m_tdata !== exp_w.pixels) begin
						$error("pixel_pair expected %h actual %h", exp_w.pixels, m_tdata);
						fail_cnt++;
					end
					if (m_tlast !== exp_w.last) begin
						$error("last_word expected %b actual %b", exp_w.last, m_tlast);
						fail_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				model_cell_command(cur_cmd);
				taken_cnt++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("text_mode_cell_renderer_tb NOT OK");
			$finish;
		end
	end

	initial begin
		cell_cmd_t c;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: corners, every command, out-of-range writes and renders
		c = random_cmd(CMD_GLYPH); c.f.code = 0; c.f.grow = 0; c.f.bits = 8'hA5;
		queue_cell_command(c);
		c = random_cmd(CMD_RENDER); c.f.line = 0; c.f.column = 0;
		queue_cell_command(c);
		c = random_cmd(CMD_PALETTE); c.f.pen = 0; c.f.fg = 16'hFFFF; c.f.bg = 16'h0000;
		queue_cell_command(c);
		c = random_cmd(CMD_PALETTE); c.f.pen = 63; c.f.fg = 16'h1234; c.f.bg = 16'hABCD;
		queue_cell_command(c);
		c = random_cmd(CMD_GLYPH); c.f.code = 255; c.f.grow = 15; c.f.bits = 8'hFF;
		queue_cell_command(c);
		c = random_cmd(CMD_GLYPH); c.f.code = 255; c.f.grow = 0; c.f.bits = 8'h00;
		queue_cell_command(c);
		c = random_cmd(CMD_CELL); c.f.row = 29; c.f.column = 79; c.f.code = 255; c.f.pen = 63;
		queue_cell_command(c);
		c = random_cmd(CMD_RENDER); c.f.line = 479; c.f.column = 79;
		queue_cell_command(c);
		c = random_cmd(CMD_RENDER); c.f.line = 464; c.f.column = 79;
		queue_cell_command(c);
		c = random_cmd(CMD_RENDER); c.f.line = 0; c.f.column = 0;
		queue_cell_command(c);
		c = random_cmd(CMD_CELL); c.f.row = 30; c.f.column = 0;
		queue_cell_command(c);
		c = random_cmd(CMD_CELL); c.f.row = 31; c.f.column = 127;
		queue_cell_command(c);
		c = random_cmd(CMD_CELL); c.f.row = 0; c.f.column = 80; c.f.code = 255; c.f.pen = 63;
		queue_cell_command(c);
		c = random_cmd(CMD_RENDER); c.f.line = 480; c.f.column = 0;
		queue_cell_command(c);
		c = random_cmd(CMD_RENDER); c.f.line = 511; c.f.column = 127;
		queue_cell_command(c);
		c = random_cmd(CMD_RENDER); c.f.line = 0; c.f.column = 80;
		queue_cell_command(c);
		c = random_cmd(CMD_RENDER); c.f.line = 16; c.f.column = 0;
		queue_cell_command(c);
		c = random_cmd(CMD_GLYPH); c.f.code = 0; c.f.grow = 0; c.f.bits = 8'h5A;
		queue_cell_command(c);
		c = random_cmd(CMD_RENDER); c.f.line = 0; c.f.column = 0;
		queue_cell_command(c);
		c = random_cmd(CMD_PALETTE); c.f.pen = 0; c.f.fg = 16'h0000; c.f.bg = 16'hFFFF;
		queue_cell_command(c);
		c = random_cmd(CMD_RENDER); c.f.line = 0; c.f.column = 0;
		queue_cell_command(c);
		wait_drained();

		run_random_phase(40, 0, 0);
		run_random_phase(40, 46, 0);
		// hold the output long enough that the block backs up into its input
		hold_left = LONG_HOLD;
		run_random_phase(40, 0, 46);
		run_random_phase(40, 35, 35);

		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("text_mode_cell_renderer_tb OK");
		else
			$display("text_mode_cell_renderer_tb NOT OK");
		$finish;
	end

endmodule

>>> files.f
rtl/core/tmcr_pkg.sv
rtl/core/tmcr_ram.sv
rtl/core/text_mode_cell_renderer.sv
tb/text_mode_cell_renderer_tb.sv
